>>> rtl/core/timer_table_scheduler_top_assert.svh
// Assertion macros for the timer table scheduler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TIMER_TABLE_SCHEDULER_TOP_ASSERT_SVH
`define TIMER_TABLE_SCHEDULER_TOP_ASSERT_SVH

// implication checked every cycle outside reset
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following cycle
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the timer table scheduler.
// No dependencies.
package tts_pkg;

  localparam int SLOTS_DEF     = 32;
  localparam int MAX_FIRES_DEF = 16;
  localparam int TIME_W        = 64;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_RESTART = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_PROCESS = 3'd3;
  localparam logic [2:0] MODE_QUERY   = 3'd4;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_INACTIVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic best_v;
    logic group;
    logic free_v;
  } scan_flags_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> rtl/core/tts_in_if.sv
`timescale 1ns / 1ps
// Request channel of the timer table scheduler.
// Depends on nothing.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] now;
  logic [4:0]  timer_id;
  logic [63:0] interval;
  logic        periodic;
  logic        free_after_fire;

  modport source (output valid, mode, now, timer_id, interval, periodic, free_after_fire,
                  input ready);
  modport sink (input valid, mode, now, timer_id, interval, periodic, free_after_fire,
                output ready);
endinterface

>>> rtl/core/tts_out_if.sv
`timescale 1ns / 1ps
// Result channel of the timer table scheduler.
// Depends on nothing.
interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  slot_id;
  logic [1:0]  status;
  logic        fired;
  logic        new_earliest;
  logic [63:0] sleep_time;
  logic        last;

  modport source (output valid, slot_id, status, fired, new_earliest, sleep_time, last,
                  input ready);
  modport sink (input valid, slot_id, status, fired, new_earliest, sleep_time, last,
                output ready);
endinterface

>>> rtl/core/timer_table_scheduler_top.sv
`timescale 1ns / 1ps
// Timer table scheduler. A request is taken in idle, the due and period memories
// are scanned (one read a cycle), then it acts once the output register is free.
// Process rescans after each fire; at the MAX_FIRES-th fire it flushes instead.
// One request at a time; a result waits in the output register and stalls the act.
// Synchronous active-low reset clears armed and allocated bits and control.
module timer_table_scheduler_top #(
  parameter int SLOTS     = tts_pkg::SLOTS_DEF,
  parameter int MAX_FIRES = tts_pkg::MAX_FIRES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tts_in_if.sink    in_ch,
  tts_out_if.source out_ch
);
  import tts_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(MAX_FIRES + 1);

  state_t          state_r, state_nxt;
  logic [SW:0]     cnt_r;
  logic            rd_v_r;
  logic [SW-1:0]   rd_idx_r;
  logic [SLOTS-1:0] armed_r, alloc_r;
  logic [FW-1:0]   nfire_r;
  logic            pend_v_r;
  logic [SW-1:0]   pend_idx_r;

  logic [2:0]      mode_r;
  logic [63:0]     now_r, ivl_r;
  logic [4:0]      id_r;
  logic            per_r, fre_r;

  logic            out_valid_r, out_fired_r, out_ne_r, out_last_r;
  logic [4:0]      out_slot_r;
  logic [1:0]      out_status_r;
  logic [63:0]     out_sleep_r;

  logic            accept, issue, scan_end, scan_clr;
  logic [SW-1:0]   id_idx;
  logic            id_ok, fire_ok;

  logic [63:0]     due_q;
  logic [65:0]     per_q;
  logic            due_we, per_we;
  logic [SW-1:0]   due_wa, upd_idx;
  logic [63:0]     due_wd;

  scan_flags_t     sf;
  logic [SW-1:0]   best_idx, free_idx;
  logic [63:0]     best_due, best_per, id_per;
  logic            best_isp, best_fre;

  logic            act_go, go_scan, go_flush;
  logic            arm_set, arm_clr, alloc_set, alloc_clr;
  logic            pend_set, pend_clr, fire_inc;
  logic            emit, e_fired, e_ne, e_last;
  logic [4:0]      e_slot;
  logic [1:0]      e_status;
  logic [63:0]     e_sleep;

  assign accept   = (state_r == ST_IDLE) && in_ch.valid;
  assign issue    = (state_r == ST_SCAN) && (cnt_r < (SW+1)'(SLOTS));
  assign scan_end = rd_v_r && (rd_idx_r == SW'(SLOTS - 1));
  assign id_idx   = SW'(id_r);
  assign id_ok    = 32'(id_r) < SLOTS;
  assign fire_ok  = sf.best_v && (best_due <= now_r);
  assign act_go   = (state_r == ST_ACT) && !out_valid_r;
  assign scan_clr = accept || (act_go && go_scan);

  assign in_ch.ready = (state_r == ST_IDLE);

  tts_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_due_ram (
    .clk(clk), .we(due_we), .waddr(due_wa), .wdata(due_wd),
    .raddr(cnt_r[SW-1:0]), .rdata(due_q)
  );

  tts_ram #(.WIDTH(66), .DEPTH(SLOTS)) u_per_ram (
    .clk(clk), .we(per_we), .waddr(free_idx), .wdata({ivl_r, per_r, fre_r}),
    .raddr(cnt_r[SW-1:0]), .rdata(per_q)
  );

  tts_scan #(.SLOTS(SLOTS)) u_scan (
    .clk(clk), .clr(scan_clr), .rd_v(rd_v_r), .rd_idx(rd_idx_r),
    .arm_bit(armed_r[rd_idx_r]), .alloc_bit(alloc_r[rd_idx_r]), .id_idx(id_idx),
    .due_q(due_q), .per_q(per_q), .ivl(ivl_r), .flags(sf),
    .best_idx(best_idx), .best_due(best_due), .best_per(best_per),
    .best_isp(best_isp), .best_fre(best_fre), .free_idx(free_idx), .id_per(id_per)
  );

  // action decode for the act and flush states
  always_comb begin
    due_we = 1'b0; per_we = 1'b0; due_wa = free_idx; due_wd = '0;
    upd_idx = free_idx;
    arm_set = 1'b0; arm_clr = 1'b0; alloc_set = 1'b0; alloc_clr = 1'b0;
    pend_set = 1'b0; pend_clr = 1'b0; fire_inc = 1'b0;
    go_scan = 1'b0; go_flush = 1'b0;
    emit = 1'b0; e_slot = '0; e_status = STS_OK; e_fired = 1'b0; e_ne = 1'b0;
    e_sleep = '0; e_last = 1'b1;
    if (act_go) begin
      case (mode_r)
        MODE_ADD: begin
          emit = 1'b1;
          if (!sf.free_v) begin
            e_status = STS_FULL;
          end else begin
            due_we = 1'b1; per_we = 1'b1;
            due_wd = sat_add(now_r, ivl_r);
            arm_set = 1'b1; alloc_set = 1'b1;
            e_slot = 5'(free_idx);
            e_ne = !sf.group && (!sf.best_v || best_due > due_wd);
          end
        end
        MODE_RESTART: begin
          emit = 1'b1;
          if (!id_ok || !armed_r[id_idx]) begin
            e_status = STS_INACTIVE;
          end else begin
            due_we = 1'b1; due_wa = id_idx;
            due_wd = sat_add(now_r, id_per);
            e_slot = id_r;
          end
        end
        MODE_DELETE: begin
          emit = 1'b1;
          if (!id_ok || !alloc_r[id_idx]) begin
            e_status = STS_INACTIVE;
          end else begin
            upd_idx = id_idx; arm_clr = 1'b1; alloc_clr = 1'b1;
            e_slot = id_r;
          end
        end
        MODE_PROCESS: begin
          if (fire_ok) begin
            // hold this fire back until the next scan tells if it is the last, or the cap flushes it
            emit = pend_v_r; e_slot = 5'(pend_idx_r); e_fired = 1'b1; e_last = 1'b0;
            pend_set = 1'b1; fire_inc = 1'b1;
            upd_idx = best_idx; due_wa = best_idx;
            if (best_isp) begin
              due_we = 1'b1; due_wd = sat_add(best_due, best_per);
            end else begin
              arm_clr = 1'b1; alloc_clr = best_fre;
            end
            if (nfire_r + FW'(1) == FW'(MAX_FIRES)) go_flush = 1'b1;
            else go_scan = 1'b1;
          end else begin
            emit = 1'b1; pend_clr = 1'b1;
            if (pend_v_r) begin
              e_slot = 5'(pend_idx_r); e_fired = 1'b1;
            end
          end
        end
        MODE_QUERY: begin
          emit = 1'b1;
          if (!sf.best_v) e_sleep = '1;
          else if (fire_ok) e_sleep = '0;
          else e_sleep = best_due - now_r;
        end
        default: emit = 1'b1;
      endcase
    end else if (state_r == ST_FLUSH && !out_valid_r) begin
      emit = 1'b1; pend_clr = 1'b1; e_slot = 5'(pend_idx_r); e_fired = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_ACT;
      ST_ACT: begin
        if (act_go) begin
          if (go_scan) state_nxt = ST_SCAN;
          else if (go_flush) state_nxt = ST_FLUSH;
          else state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: if (!out_valid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      armed_r     <= '0;
      alloc_r     <= '0;
      nfire_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (scan_clr) cnt_r <= '0;
      else if (issue) cnt_r <= cnt_r + (SW+1)'(1);
      if (arm_set)   armed_r[upd_idx] <= 1'b1;
      if (arm_clr)   armed_r[upd_idx] <= 1'b0;
      if (alloc_set) alloc_r[upd_idx] <= 1'b1;
      if (alloc_clr) alloc_r[upd_idx] <= 1'b0;
      if (accept) nfire_r <= '0;
      else if (fire_inc) nfire_r <= nfire_r + FW'(1);
      if (pend_set) pend_v_r <= 1'b1;
      else if (pend_clr || accept) pend_v_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[SW-1:0];
    if (pend_set) pend_idx_r <= best_idx;
    if (accept) begin
      mode_r <= in_ch.mode;
      now_r  <= in_ch.now;
      id_r   <= in_ch.timer_id;
      ivl_r  <= in_ch.interval;
      per_r  <= in_ch.periodic;
      fre_r  <= in_ch.free_after_fire;
    end
    if (emit) begin
      out_slot_r   <= e_slot;
      out_status_r <= e_status;
      out_fired_r  <= e_fired;
      out_ne_r     <= e_ne;
      out_sleep_r  <= e_sleep;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot_id      = out_slot_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.fired        = out_fired_r;
  assign out_ch.new_earliest = out_ne_r;
  assign out_ch.sleep_time   = out_sleep_r;
  assign out_ch.last         = out_last_r;

`include "timer_table_scheduler_top_assert.svh"

  `TTS_ASSERT_IMP(a_fire_cap, 1'b1, nfire_r <= FW'(MAX_FIRES), "fire count over cap")
  `TTS_ASSERT_IMP(a_armed_alloc, 1'b1, (armed_r & ~alloc_r) == '0, "armed slot not allocated")
  `TTS_ASSERT_NEXT(a_accept_scan, accept, state_r == ST_SCAN && cnt_r == '0, "no scan after request")
  `TTS_ASSERT_IMP(a_pend_proc, pend_v_r, mode_r == MODE_PROCESS, "pending fire outside process")

endmodule

>>> rtl/core/tts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/tts_scan.sv
`timescale 1ns / 1ps
// Scan accumulator: walks the slot memories one entry a cycle and keeps the
// earliest armed slot, the lowest free slot, the group match and the period
// of the addressed slot. Depends on tts_pkg.
module tts_scan #(
  parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      clr,
  input  logic                      rd_v,
  input  logic [$clog2(SLOTS)-1:0]  rd_idx,
  input  logic                      arm_bit,
  input  logic                      alloc_bit,
  input  logic [$clog2(SLOTS)-1:0]  id_idx,
  input  logic [63:0]               due_q,
  input  logic [65:0]               per_q,
  input  logic [63:0]               ivl,
  output tts_pkg::scan_flags_t      flags,
  output logic [$clog2(SLOTS)-1:0]  best_idx,
  output logic [63:0]               best_due,
  output logic [63:0]               best_per,
  output logic                      best_isp,
  output logic                      best_fre,
  output logic [$clog2(SLOTS)-1:0]  free_idx,
  output logic [63:0]               id_per
);
  import tts_pkg::*;

  localparam int SW = $clog2(SLOTS);

  scan_flags_t      flags_r, flags_nxt;
  logic [SW-1:0]    best_idx_r, free_idx_r;
  logic [63:0]      best_due_r, best_per_r, id_per_r;
  logic             best_isp_r, best_fre_r;
  logic             take_best, take_free;

  always_comb begin
    take_best = rd_v && arm_bit && (!flags_r.best_v || due_q < best_due_r);
    take_free = rd_v && !alloc_bit && !flags_r.free_v;
    flags_nxt = flags_r;
    if (take_best) flags_nxt.best_v = 1'b1;
    if (take_free) flags_nxt.free_v = 1'b1;
    if (rd_v && arm_bit && per_q[65:2] == ivl) flags_nxt.group = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    if (take_best) begin
      best_idx_r <= rd_idx;
      best_due_r <= due_q;
      best_per_r <= per_q[65:2];
      best_isp_r <= per_q[1];
      best_fre_r <= per_q[0];
    end
    if (take_free) free_idx_r <= rd_idx;
    if (rd_v && rd_idx == id_idx) id_per_r <= per_q[65:2];
  end

  assign flags    = flags_r;
  assign best_idx = best_idx_r;
  assign best_due = best_due_r;
  assign best_per = best_per_r;
  assign best_isp = best_isp_r;
  assign best_fre = best_fre_r;
  assign free_idx = free_idx_r;
  assign id_per   = id_per_r;
endmodule

>>> test/tb_timer_table_scheduler_top.sv
`timescale 1ns / 1ps
// Testbench for the timer table scheduler: directed and random requests, with
// a built-in slot table predictor. Depends on tts_pkg, tts_in_if, tts_out_if, timer_table_scheduler_top.
module tb_timer_table_scheduler_top;
  import tts_pkg::*;

  localparam int NSLOT = 32;
  localparam int FIRE_CAP = 16;
  localparam logic [63:0] TMAX = {64{1'b1}};

  typedef struct packed {
    logic [4:0]  slot_id;
    logic [1:0]  status;
    logic        fired;
    logic        new_earliest;
    logic [63:0] sleep_time;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tts_in_if  in_ch();
  tts_out_if out_ch();

  timer_table_scheduler_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor copy of the slot table
  logic [63:0] tbl_due [NSLOT];
  logic [63:0] tbl_per [NSLOT];
  logic        tbl_periodic [NSLOT];
  logic        tbl_free [NSLOT];
  logic        tbl_armed [NSLOT];
  logic        tbl_alloc [NSLOT];

  result_t expected_q[$];
  int errors = 0;
  logic [63:0] clock_now = 64'd0;
  logic rx_enable = 1'b1;
  logic rx_noidle = 1'b0;
  logic tx_noidle = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? TMAX : s[63:0];
  endfunction

  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_armed[i] && (best < 0 || tbl_due[i] < tbl_due[best])) best = i;
    return best;
  endfunction

  function automatic result_t mk(int slot, logic [1:0] st, logic f, logic ne,
                                 logic [63:0] sl, logic lst);
    result_t r;
    r.slot_id = slot[4:0];
    r.status = st;
    r.fired = f;
    r.new_earliest = ne;
    r.sleep_time = sl;
    r.last = lst;
    return r;
  endfunction

  // work out the results of one accepted request and queue them
  task automatic predict_results(logic [2:0] mode, logic [63:0] now, logic [4:0] id,
                                 logic [63:0] intv, logic per, logic fre);
    int slot, e, n;
    logic grp, ne;
    logic [63:0] due;
    case (mode)
      MODE_ADD: begin
        slot = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_alloc[i]) slot = i;
        if (slot < 0) begin
          expected_q.push_back(mk(0, STS_FULL, 0, 0, 0, 1));
        end else begin
          due = add_sat(now, intv);
          grp = 1'b0;
          for (int i = 0; i < NSLOT; i++) if (tbl_armed[i] && tbl_per[i] == intv) grp = 1'b1;
          e = earliest_armed();
          ne = !grp && (e < 0 || tbl_due[e] > due);
          tbl_due[slot] = due;
          tbl_per[slot] = intv;
          tbl_periodic[slot] = per;
          tbl_free[slot] = fre;
          tbl_armed[slot] = 1'b1;
          tbl_alloc[slot] = 1'b1;
          expected_q.push_back(mk(slot, STS_OK, 0, ne, 0, 1));
        end
      end
      MODE_RESTART: begin
        if (!tbl_armed[id]) begin
          expected_q.push_back(mk(0, STS_INACTIVE, 0, 0, 0, 1));
        end else begin
          tbl_due[id] = add_sat(now, tbl_per[id]);
          expected_q.push_back(mk(id, STS_OK, 0, 0, 0, 1));
        end
      end
      MODE_DELETE: begin
        if (!tbl_alloc[id]) begin
          expected_q.push_back(mk(0, STS_INACTIVE, 0, 0, 0, 1));
        end else begin
          tbl_armed[id] = 1'b0;
          tbl_alloc[id] = 1'b0;
          expected_q.push_back(mk(id, STS_OK, 0, 0, 0, 1));
        end
      end
      MODE_PROCESS: begin
        n = 0;
        while (n < FIRE_CAP) begin
          e = earliest_armed();
          if (e < 0 || tbl_due[e] > now) break;
          if (tbl_periodic[e]) begin
            tbl_due[e] = add_sat(tbl_due[e], tbl_per[e]);
          end else begin
            tbl_armed[e] = 1'b0;
            if (tbl_free[e]) tbl_alloc[e] = 1'b0;
          end
          expected_q.push_back(mk(e, STS_OK, 1, 0, 0, 0));
          n++;
        end
        if (n == 0) expected_q.push_back(mk(0, STS_OK, 0, 0, 0, 1));
        else expected_q[$].last = 1'b1;
      end
      MODE_QUERY: begin
        e = earliest_armed();
        if (e < 0) due = TMAX;
        else if (tbl_due[e] <= now) due = 64'd0;
        else due = tbl_due[e] - now;
        expected_q.push_back(mk(0, STS_OK, 0, 0, due, 1));
      end
      default: begin
        expected_q.push_back(mk(0, STS_OK, 0, 0, 0, 1));
      end
    endcase
  endtask

  // drive one request and hold it until accepted
  task automatic send_request(logic [2:0] mode, logic [63:0] now, logic [4:0] id,
                              logic [63:0] intv, logic per, logic fre);
    do @(negedge clk); while (!tx_noidle && $urandom_range(99) < 16);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.now <= now;
    in_ch.timer_id <= id;
    in_ch.interval <= intv;
    in_ch.periodic <= per;
    in_ch.free_after_fire <= fre;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_results(mode, now, id, intv, per, fre);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // receiver ready, with random stalls
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= rx_enable && (rx_noidle || $urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk(out_ch.slot_id, out_ch.status, out_ch.fired, out_ch.new_earliest,
               out_ch.sleep_time, out_ch.last);
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.slot_id != want.slot_id) begin
          $display("%0t slot_id exp %0d got %0d", $time, want.slot_id, got.slot_id);
          errors++;
        end
        if (got.status != want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.fired != want.fired) begin
          $display("%0t fired exp %0d got %0d", $time, want.fired, got.fired);
          errors++;
        end
        if (got.new_earliest != want.new_earliest) begin
          $display("%0t new_earliest exp %0d got %0d", $time, want.new_earliest,
                   got.new_earliest);
          errors++;
        end
        if (got.sleep_time != want.sleep_time) begin
          $display("%0t sleep_time exp %h got %h", $time, want.sleep_time, got.sleep_time);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t last exp %0d got %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_extremes();
    send_request(MODE_QUERY, 64'd0, 0, 0, 0, 0);
    send_request(MODE_PROCESS, 64'd0, 0, 0, 0, 0);
    send_request(MODE_RESTART, 64'd0, 5'd31, 0, 0, 0);
    send_request(MODE_DELETE, 64'd0, 5'd0, 0, 0, 0);
    send_request(MODE_ADD, TMAX, 0, TMAX, 1, 1);
    send_request(MODE_ADD, 64'd0, 0, 64'd0, 0, 0);
    send_request(MODE_ADD, 64'd5, 0, TMAX, 0, 1);
    send_request(MODE_ADD, 64'd1, 0, 64'd10, 1, 0);
    send_request(MODE_QUERY, 64'd3, 0, 0, 0, 0);
    send_request(MODE_QUERY, TMAX, 0, 0, 0, 0);
    send_request(MODE_RESTART, 64'd2, 5'd3, 0, 1, 1);
    send_request(MODE_PROCESS, 64'd40, 0, 0, 0, 0);
    send_request(MODE_DELETE, 64'd0, 5'd1, 0, 0, 0);
    send_request(MODE_RESTART, 64'd0, 5'd1, 0, 0, 0);
    send_request(3'd5, TMAX, 5'd31, TMAX, 1, 1);
    send_request(3'd6, 64'd0, 0, 0, 0, 0);
    send_request(3'd7, 64'd0, 0, 0, 0, 0);
    wait_drained();
  endtask

  // fill the table, hit full, burst process past the fire cap, then delete every slot
  task automatic test_full_and_cap();
    for (int i = 0; i < 34; i++) send_request(MODE_ADD, 64'd100, 0, 64'd1, 1, 0);
    send_request(MODE_PROCESS, 64'd200, 0, 0, 0, 0);
    send_request(MODE_PROCESS, 64'd200, 0, 0, 0, 0);
    for (int i = 0; i < NSLOT; i++) send_request(MODE_DELETE, 0, i[4:0], 0, 0, 0);
    wait_drained();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        rx_enable = 1'b0;
        repeat (600) @(negedge clk);
        rx_enable = 1'b1;
      end
      for (int i = 0; i < 10; i++) send_request(MODE_QUERY, rand64(), 0, 0, 0, 0);
    join
    wait_drained();
  endtask

  task automatic test_random(int count);
    int used;
    logic [2:0] mode;
    logic [63:0] intv;
    for (int i = 0; i < count; i++) begin
      tx_noidle = (i >= 100 && i < 160);
      rx_noidle = tx_noidle;
      used = 0;
      for (int s = 0; s < NSLOT; s++) used += tbl_alloc[s];
      clock_now = clock_now + 64'($urandom_range(60));
      case ($urandom_range(9))
        0, 1, 2: mode = (used > 20) ? MODE_DELETE : MODE_ADD;
        3: mode = MODE_RESTART;
        4: mode = MODE_DELETE;
        5, 6: mode = MODE_PROCESS;
        7, 8: mode = MODE_QUERY;
        default: mode = 3'($urandom_range(7));
      endcase
      case ($urandom_range(9))
        0: intv = rand64();
        1: intv = 64'd0;
        default: intv = 64'($urandom_range(80));
      endcase
      send_request(mode, ($urandom_range(19) == 0) ? rand64() : clock_now,
                   5'($urandom_range(31)), intv, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      if (i == 200) wait_drained();
    end
    tx_noidle = 1'b0;
    rx_noidle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_armed[i] = 1'b0;
      tbl_alloc[i] = 1'b0;
      tbl_due[i] = '0;
      tbl_per[i] = '0;
      tbl_periodic[i] = 1'b0;
      tbl_free[i] = 1'b0;
    end
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_QUERY;
    in_ch.now = '0;
    in_ch.timer_id = '0;
    in_ch.interval = '0;
    in_ch.periodic = 1'b0;
    in_ch.free_after_fire = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_full_and_cap();
    test_backpressure();
    test_random(280);
    wait_drained();
    repeat (600) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_in_if.sv
rtl/core/tts_out_if.sv
rtl/core/tts_ram.sv
rtl/core/tts_scan.sv
rtl/core/timer_table_scheduler_top.sv
test/tb_timer_table_scheduler_top.sv
